// File: hw/rtl/address_to_position_table_core_macros.svh
// Assertion macros for the address to position table core.
`ifndef ADDRESS_TO_POSITION_TABLE_CORE_MACROS_SVH
`define ADDRESS_TO_POSITION_TABLE_CORE_MACROS_SVH

// Checked only while out of reset.
`define ATPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ATPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: hw/rtl/atpt_pkg.sv
// Shared types and codes of the address to position table.
`default_nettype none

package atpt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_QUERY  = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    // Request token that walks down the chain of cells.
    typedef struct packed {
        logic        vld;
        logic        wr;          // write pass of an add, else scan pass
        logic [2:0]  op;
        logic [31:0] key;
        logic [63:0] pos_x;       // request coordinates, or stored ones after a get hit
        logic [63:0] pos_y;
        logic [63:0] pos_z;
        logic        hit;
        logic        free_found;
    } tok_t;

endpackage

`default_nettype wire

// File: hw/rtl/atpt_cell.sv
// One table slot of the chain: holds an entry and forwards the request token.
`default_nettype none

module atpt_cell #(
    parameter int               IDX_W      = 6,
    parameter logic [IDX_W-1:0] CELL_INDEX = '0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire atpt_pkg::tok_t   tok_i,
    input  wire logic [IDX_W-1:0] idx_i,
    output atpt_pkg::tok_t        tok_o,
    output logic [IDX_W-1:0]      idx_o
);

    logic           valid_reg, valid_next;
    logic [31:0]    key_reg;
    logic [63:0]    pos_x_reg, pos_y_reg, pos_z_reg;
    atpt_pkg::tok_t tok_reg, tok_next;
    logic           tok_vld_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic scan;
    logic match;
    logic wr_hit;
    logic load_pos;

    always_comb begin
        scan     = tok_i.vld && !tok_i.wr;
        match    = scan && valid_reg && (key_reg == tok_i.key) && !tok_i.hit;
        wr_hit   = tok_i.vld && tok_i.wr && (idx_i == CELL_INDEX);
        load_pos = wr_hit || (match && (tok_i.op == atpt_pkg::OP_UPDATE));

        tok_next = tok_i;
        idx_next = idx_i;
        // claim the lowest free slot seen so far
        if (scan && !valid_reg && !tok_i.free_found) begin
            tok_next.free_found = 1'b1;
            idx_next            = CELL_INDEX;
        end
        if (match) begin
            tok_next.hit = 1'b1;
            if (tok_i.op == atpt_pkg::OP_GET) begin
                tok_next.pos_x = pos_x_reg;
                tok_next.pos_y = pos_y_reg;
                tok_next.pos_z = pos_z_reg;
            end
        end

        valid_next = valid_reg;
        if (match && (tok_i.op == atpt_pkg::OP_REMOVE)) begin
            valid_next = 1'b0;
        end
        if (wr_hit) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            tok_vld_reg <= tok_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
        idx_reg <= idx_next;
        if (wr_hit) begin
            key_reg <= tok_i.key;
        end
        if (load_pos) begin
            pos_x_reg <= tok_i.pos_x;
            pos_y_reg <= tok_i.pos_y;
            pos_z_reg <= tok_i.pos_z;
        end
    end

    always_comb begin
        tok_o     = tok_reg;
        tok_o.vld = tok_vld_reg;
    end

    assign idx_o = idx_reg;

endmodule

`default_nettype wire

// File: hw/rtl/address_to_position_table_core.sv
// Top level of the address to position table: request sequencer and chain of slots.
`default_nettype none

// Associative table of TABLE_ENTRIES slots, each mapping an IPv4 address to
// three 64-bit coordinate words kept as raw bits. Every request beat walks a
// chain of slot cells, one cell per cycle, from accept to result; a successful
// add walks the chain a second time to write the lowest free slot. One request
// is in flight at a time; the next beat is taken once the previous result sits
// in the output register.
// Slot valid marks clear at reset. s_tdata, from bit 0 up: opcode[2:0],
// key_address[31:0], pos_x_in, pos_y_in, pos_z_in (64 bits each), zero fill.
// m_tdata, from bit 0 up: status[1:0], pos_x_out, pos_y_out, pos_z_out, zero fill.
module address_to_position_table_core #(
    parameter int TABLE_ENTRIES = atpt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // opcode[2:0], key_address[31:0], pos_x_in[63:0], pos_y_in[63:0],
    // pos_z_in[63:0], zero fill
    input  wire logic [231:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], pos_x_out[63:0], pos_y_out[63:0], pos_z_out[63:0], zero fill
    output logic [199:0]      m_tdata
);

    `include "address_to_position_table_core_macros.svh"

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;

    atpt_pkg::tok_t   chain_tok [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] chain_idx [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] tok_vld_vec;

    atpt_pkg::tok_t   exit_tok;
    logic [IDX_W-1:0] exit_idx;
    atpt_pkg::tok_t   fin_tok_reg, fin_tok_next;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [199:0] m_tdata_reg, m_tdata_next;

    logic         s_accept;
    logic         commit;
    logic         out_load;
    logic [1:0]   status;
    logic [63:0]  ox, oy, oz;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign exit_tok = chain_tok[TABLE_ENTRIES];
    assign exit_idx = chain_idx[TABLE_ENTRIES];
    assign commit   = (exit_tok.op == atpt_pkg::OP_ADD) && exit_tok.free_found && !exit_tok.hit;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // Inject the request, or the write pass of a successful add.
    always_comb begin
        chain_tok[0] = '0;
        chain_idx[0] = exit_idx;
        if (s_accept) begin
            chain_tok[0].vld   = 1'b1;
            chain_tok[0].op    = s_tdata[2:0];
            chain_tok[0].key   = s_tdata[34:3];
            chain_tok[0].pos_x = s_tdata[98:35];
            chain_tok[0].pos_y = s_tdata[162:99];
            chain_tok[0].pos_z = s_tdata[226:163];
        end else if ((state_reg == S_SCAN) && exit_tok.vld && commit) begin
            chain_tok[0]    = exit_tok;
            chain_tok[0].wr = 1'b1;
        end
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        atpt_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (IDX_W'(i))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (chain_tok[i]),
            .idx_i   (chain_idx[i]),
            .tok_o   (chain_tok[i+1]),
            .idx_o   (chain_idx[i+1])
        );
        assign tok_vld_vec[i] = chain_tok[i+1].vld;
    end

    always_comb begin
        status = atpt_pkg::ST_MISS;
        case (fin_tok_reg.op)
            atpt_pkg::OP_ADD: begin
                if (!fin_tok_reg.free_found) begin
                    status = atpt_pkg::ST_FULL;
                end else if (fin_tok_reg.hit) begin
                    status = atpt_pkg::ST_DUP;
                end else begin
                    status = atpt_pkg::ST_OK;
                end
            end
            atpt_pkg::OP_QUERY, atpt_pkg::OP_GET, atpt_pkg::OP_UPDATE,
            atpt_pkg::OP_REMOVE: begin
                status = fin_tok_reg.hit ? atpt_pkg::ST_OK : atpt_pkg::ST_MISS;
            end
            default: status = atpt_pkg::ST_MISS;
        endcase
        if ((fin_tok_reg.op == atpt_pkg::OP_GET) && fin_tok_reg.hit) begin
            ox = fin_tok_reg.pos_x;
            oy = fin_tok_reg.pos_y;
            oz = fin_tok_reg.pos_z;
        end else begin
            ox = '0;
            oy = '0;
            oz = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fin_tok_next  = fin_tok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (exit_tok.vld) begin
                    fin_tok_next = exit_tok;
                    state_next   = commit ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: begin
                if (exit_tok.vld) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, oz, oy, ox, status};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_tok_reg <= fin_tok_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ATPT_ASSERT(a_one_token, $onehot0(tok_vld_vec), "more than one token in the chain")
    `ATPT_ASSERT(a_idle_empty, s_tready |-> (tok_vld_vec == '0),
        "ready while a token is still in the chain")
    `ATPT_ASSERT(a_write_add, (state_reg == S_WRITE) |-> (fin_tok_reg.op == atpt_pkg::OP_ADD),
        "write pass for a request that is not an add")
    `ATPT_ASSERT_ALWAYS(a_reset_out, !aresetn |=> (!m_tvalid && (tok_vld_vec == '0)),
        "output or chain not cleared by reset")

endmodule

`default_nettype wire

// File: tb/tb_address_to_position_table_core.sv
// Self-checking testbench for the address to position table core.
`timescale 1ns / 1ps

module tb_address_to_position_table_core;

    localparam int NUM_SLOTS        = atpt_pkg::TABLE_ENTRIES_DEF;
    localparam int KEY_POOL_SIZE    = NUM_SLOTS + NUM_SLOTS / 2;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int DRAIN_CYCLES     = 2 * NUM_SLOTS + 8;
    localparam int CYCLE_LIMIT      = 1_000_000;

    // Opcodes with no meaning
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [63:0] pos_z;
    } reply_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // opcode, key_address, pos_x_in, pos_y_in, pos_z_in, zero fill
    logic [231:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, pos_x_out, pos_y_out, pos_z_out, zero fill
    logic [199:0] m_tdata;

    // Shadow copy of the table
    logic        slot_used [NUM_SLOTS];
    logic [31:0] slot_key  [NUM_SLOTS];
    logic [63:0] slot_x    [NUM_SLOTS];
    logic [63:0] slot_y    [NUM_SLOTS];
    logic [63:0] slot_z    [NUM_SLOTS];

    reply_t      reply_q[$];
    logic [31:0] key_pool [KEY_POOL_SIZE];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int beats_in     = 0;
    int status_count [4] = '{default: 0};

    address_to_position_table_core #(
        .TABLE_ENTRIES(NUM_SLOTS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] rand_bits64();
        return {$urandom(), $urandom()};
    endfunction

    // Apply one request to the shadow table and return the reply it must produce.
    function automatic reply_t predict_table_reply(input logic [2:0] op,
            input logic [31:0] key, input logic [63:0] x, input logic [63:0] y,
            input logic [63:0] z);
        reply_t r;
        int     hit;
        int     free_slot;
        r = '{status: atpt_pkg::ST_MISS, pos_x: '0, pos_y: '0, pos_z: '0};
        hit = -1;
        free_slot = -1;
        // Walk downward so the lowest index wins
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_key[i] == key)
                hit = i;
            if (!slot_used[i])
                free_slot = i;
        end
        case (op)
            atpt_pkg::OP_ADD: begin
                if (free_slot < 0) begin
                    r.status = atpt_pkg::ST_FULL;
                end else if (hit >= 0) begin
                    r.status = atpt_pkg::ST_DUP;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot]  = key;
                    slot_x[free_slot]    = x;
                    slot_y[free_slot]    = y;
                    slot_z[free_slot]    = z;
                    r.status = atpt_pkg::ST_OK;
                end
            end
            atpt_pkg::OP_QUERY: begin
                if (hit >= 0)
                    r.status = atpt_pkg::ST_OK;
            end
            atpt_pkg::OP_GET: begin
                if (hit >= 0) begin
                    r.pos_x  = slot_x[hit];
                    r.pos_y  = slot_y[hit];
                    r.pos_z  = slot_z[hit];
                    r.status = atpt_pkg::ST_OK;
                end
            end
            atpt_pkg::OP_UPDATE: begin
                if (hit >= 0) begin
                    slot_x[hit] = x;
                    slot_y[hit] = y;
                    slot_z[hit] = z;
                    r.status = atpt_pkg::ST_OK;
                end
            end
            atpt_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    slot_used[hit] = 1'b0;
                    r.status = atpt_pkg::ST_OK;
                end
            end
            default: r.status = atpt_pkg::ST_MISS;
        endcase
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
            input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Predict on every request beat, check every result beat.
    always @(posedge aclk) begin : beat_monitor
        reply_t want;
        reply_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = predict_table_reply(s_tdata[2:0], s_tdata[34:3], s_tdata[98:35],
                                           s_tdata[162:99], s_tdata[226:163]);
                reply_q.push_back(want);
                status_count[want.status]++;
                beats_in++;
            end
            if (m_tvalid && m_tready) begin
                got = '{status: m_tdata[1:0], pos_x: m_tdata[65:2],
                        pos_y: m_tdata[129:66], pos_z: m_tdata[193:130]};
                if (reply_q.size() == 0) begin
                    $display("%0t: result beat with no request waiting, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("pos_z", want.pos_z, got.pos_z);
                end
            end
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
                     reply_q.size());
            $display("tb_address_to_position_table_core NOT OK");
            $finish;
        end
    end

    // Leaves s_tvalid high after the beat; wait_for_replies drops it.
    task automatic send_req(input logic [2:0] op, input logic [31:0] key,
            input logic [63:0] x, input logic [63:0] y, input logic [63:0] z);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {5'b0, z, y, x, key, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_keyed(input logic [2:0] op, input logic [31:0] key);
        send_req(op, key, rand_bits64(), rand_bits64(), rand_bits64());
    endtask

    task automatic wait_for_replies();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_directed();
        // Misses on an empty table
        send_keyed(atpt_pkg::OP_GET, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_QUERY, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_UPDATE, 32'hFFFF_FFFF);
        send_keyed(atpt_pkg::OP_REMOVE, 32'hFFFF_FFFF);
        // Extreme keys and coordinates
        send_req(atpt_pkg::OP_ADD, 32'h0000_0000, '0, '0, '0);
        send_req(atpt_pkg::OP_ADD, 32'hFFFF_FFFF, '1, '1, '1);
        send_keyed(atpt_pkg::OP_ADD, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_QUERY, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_GET, 32'hFFFF_FFFF);
        send_keyed(atpt_pkg::OP_GET, 32'h0000_0000);
        send_req(atpt_pkg::OP_UPDATE, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0001);
        send_keyed(atpt_pkg::OP_GET, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_REMOVE, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_REMOVE, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_GET, 32'h0000_0000);
        send_keyed(atpt_pkg::OP_QUERY, 32'h0000_0000);
        // Undefined opcodes must leave the table alone
        for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++)
            send_keyed(3'(op), 32'hFFFF_FFFF);
        send_keyed(atpt_pkg::OP_GET, 32'hFFFF_FFFF);
        // Freed slot gets reused
        send_keyed(atpt_pkg::OP_ADD, 32'hC0A8_0001);
        send_keyed(atpt_pkg::OP_GET, 32'hC0A8_0001);
        send_keyed(atpt_pkg::OP_GET, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_drain();
        logic [31:0] resident[$];
        wait_for_replies();
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_used[i])
                resident.push_back(slot_key[i]);
        foreach (resident[i])
            send_keyed(atpt_pkg::OP_REMOVE, resident[i]);
        for (int i = 0; i < NUM_SLOTS; i++)
            send_keyed(atpt_pkg::OP_ADD, key_pool[i]);
        send_keyed(atpt_pkg::OP_ADD, key_pool[NUM_SLOTS]);
        // Full is reported ahead of duplicate
        send_keyed(atpt_pkg::OP_ADD, key_pool[3]);
        send_keyed(atpt_pkg::OP_QUERY, key_pool[NUM_SLOTS]);
        send_keyed(atpt_pkg::OP_GET, key_pool[NUM_SLOTS - 1]);
        send_keyed(atpt_pkg::OP_UPDATE, key_pool[0]);
        send_keyed(atpt_pkg::OP_GET, key_pool[0]);
        send_keyed(atpt_pkg::OP_REMOVE, key_pool[NUM_SLOTS / 2]);
        send_keyed(atpt_pkg::OP_ADD, key_pool[NUM_SLOTS]);
        send_keyed(atpt_pkg::OP_ADD, key_pool[NUM_SLOTS + 1]);
        send_keyed(atpt_pkg::OP_GET, key_pool[NUM_SLOTS]);
        // Drain half so random traffic starts mid-range
        for (int i = 0; i < NUM_SLOTS; i += 2)
            send_keyed(atpt_pkg::OP_REMOVE, key_pool[i]);
    endtask

    task automatic test_random_traffic(input int count);
        logic [2:0]  op;
        logic [31:0] key;
        int          pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 30)
                op = atpt_pkg::OP_ADD;
            else if (pick < 45)
                op = atpt_pkg::OP_QUERY;
            else if (pick < 65)
                op = atpt_pkg::OP_GET;
            else if (pick < 80)
                op = atpt_pkg::OP_UPDATE;
            else if (pick < 95)
                op = atpt_pkg::OP_REMOVE;
            else
                op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
            // Mostly pooled keys so hits, duplicates and a full table all occur
            if ($urandom_range(99) < 85)
                key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            else
                key = $urandom();
            send_keyed(op, key);
        end
    endtask

    initial begin : run_tests
        logic [31:0] cand;
        bit          clash;
        for (int i = 0; i < NUM_SLOTS; i++)
            slot_used[i] = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_SIZE; i++) begin
            do begin
                cand  = $urandom();
                clash = 1'b0;
                for (int j = 0; j < i; j++)
                    if (key_pool[j] == cand)
                        clash = 1'b1;
            end while (clash);
            key_pool[i] = cand;
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 31;
        snk_idle_pct = 87;
        test_directed();
        test_fill_and_drain();
        test_random_traffic(RANDOM_PER_PHASE);

        src_idle_pct = 87;
        snk_idle_pct = 31;
        test_random_traffic(RANDOM_PER_PHASE);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(RANDOM_PER_PHASE);

        wait_for_replies();
        // Catch any stray result beats
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests under three stall mixes, incl. directed and table-fill runs",
                 beats_in);
        $display("Replies: %0d success, %0d full, %0d duplicate, %0d not found; %0d mismatches",
                 status_count[atpt_pkg::ST_OK], status_count[atpt_pkg::ST_FULL],
                 status_count[atpt_pkg::ST_DUP], status_count[atpt_pkg::ST_MISS], fail_count);
        if (fail_count == 0)
            $display("tb_address_to_position_table_core OK");
        else
            $display("tb_address_to_position_table_core NOT OK");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/atpt_pkg.sv
hw/rtl/atpt_cell.sv
hw/rtl/address_to_position_table_core.sv
tb/tb_address_to_position_table_core.sv
